// ----- src/sbsi_pkg.sv -----
// Shared constants for the segment/box slab intersection block.
`timescale 1ns / 1ps
`default_nettype none
package sbsi_pkg;

	localparam int NUM_AXES  = 3;
	localparam int NUM_LANES = 2 * NUM_AXES;
	localparam int THR_BITS  = 17;

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

endpackage
`default_nettype wire

// ----- src/segment_box_slab_intersection.sv -----
// Segment against axis-aligned box slab test, fully pipelined.
//
//   channel   direction  handshake           beat carries
//   in        input      in_valid/in_stall   start, end, box min and max corners
//   cfg       input      cfg_valid/cfg_ready parallel_threshold
//   out       output     out_valid/out_stall hit, entry_t, normal_axis, normal_positive
//
// One item per cycle while out_stall does not hold the pipeline; its length is set by the
// restoring divider that resolves one quotient bit per stage over COORD_BITS+1 stages.
// arst_n clears valid bits and resets the threshold to 1; data registers are not reset.
// A stall at the output holds only the stages that are full behind it; bubbles
// ahead of it still close up, so in_stall rises only when every stage is occupied.
`timescale 1ns / 1ps
`default_nettype none
module segment_box_slab_intersection #(
	parameter int COORD_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [sbsi_pkg::THR_BITS-1:0]     parallel_threshold,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [COORD_BITS-1:0]      start_x,
	input  wire logic signed [COORD_BITS-1:0]      start_y,
	input  wire logic signed [COORD_BITS-1:0]      start_z,
	input  wire logic signed [COORD_BITS-1:0]      end_x,
	input  wire logic signed [COORD_BITS-1:0]      end_y,
	input  wire logic signed [COORD_BITS-1:0]      end_z,
	input  wire logic signed [COORD_BITS-1:0]      box_min_x,
	input  wire logic signed [COORD_BITS-1:0]      box_min_y,
	input  wire logic signed [COORD_BITS-1:0]      box_min_z,
	input  wire logic signed [COORD_BITS-1:0]      box_max_x,
	input  wire logic signed [COORD_BITS-1:0]      box_max_y,
	input  wire logic signed [COORD_BITS-1:0]      box_max_z,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   hit,
	output logic [FRAC_BITS:0]                     entry_t,
	output logic [1:0]                             normal_axis,
	output logic                                   normal_positive
);
	import sbsi_pkg::*;

	localparam int NW = COORD_BITS + 1;
	localparam int NS = NW + 6;
	localparam int SA = NW + 2;
	localparam int SB = NW + 3;
	localparam int SC = NW + 4;
	localparam int SD = NW + 5;
	localparam logic [NW-1:0] LIM = NW'(1) << (COORD_BITS - 1);
	localparam logic signed [COORD_BITS-1:0] T_ONE = COORD_BITS'(1) << FRAC_BITS;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] tmin;
		logic signed [COORD_BITS-1:0] tmax;
		logic [1:0]                   axis;
		logic                         pos;
		logic                         miss;
	} acc_t;

	function automatic acc_t slab_step(input acc_t a, input logic signed [COORD_BITS-1:0] lo,
			input logic signed [COORD_BITS-1:0] hi, input logic p, input logic par,
			input logic [1:0] ax);
		acc_t r;
		r = a;
		if (!par) begin
			if (lo > r.tmin) begin
				r.tmin = lo;
				r.axis = ax;
				r.pos  = p;
			end
			if (hi < r.tmax) begin
				r.tmax = hi;
			end
			if (r.tmin > r.tmax) begin
				r.miss = 1'b1;
			end
		end
		return r;
	endfunction

	logic [THR_BITS-1:0] thr_q;
	logic [NS-1:0]       vld_q;
	logic [NS-1:0]       en;

	// config register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid) begin
			thr_q <= parallel_threshold;
		end
	end

	// advance chain: a stage moves when empty or when the stage after it moves
	genvar gk;
	generate
		for (gk = 0; gk < NS; gk++) begin : g_en
			if (gk == NS - 1) begin : g_last
				assign en[gk] = !vld_q[gk] || !out_stall;
			end else begin : g_mid
				assign en[gk] = !vld_q[gk] || en[gk+1];
			end
		end
	endgenerate

	assign in_stall  = !en[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= (k == 0) ? in_valid : vld_q[(k == 0) ? 0 : k - 1];
				end
			end
		end
	end

	// stage 1: differences
	logic signed [COORD_BITS-1:0] s_in  [NUM_AXES];
	logic signed [COORD_BITS-1:0] e_in  [NUM_AXES];
	logic signed [COORD_BITS-1:0] lo_in [NUM_AXES];
	logic signed [COORD_BITS-1:0] hi_in [NUM_AXES];

	assign s_in[0]  = start_x;
	assign s_in[1]  = start_y;
	assign s_in[2]  = start_z;
	assign e_in[0]  = end_x;
	assign e_in[1]  = end_y;
	assign e_in[2]  = end_z;
	assign lo_in[0] = box_min_x;
	assign lo_in[1] = box_min_y;
	assign lo_in[2] = box_min_z;
	assign hi_in[0] = box_max_x;
	assign hi_in[1] = box_max_y;
	assign hi_in[2] = box_max_z;

	logic signed [NW-1:0] d_s1   [NUM_AXES];
	logic signed [NW-1:0] nlo_s1 [NUM_AXES];
	logic signed [NW-1:0] nhi_s1 [NUM_AXES];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				d_s1[a]   <= NW'(e_in[a]) - NW'(s_in[a]);
				nlo_s1[a] <= NW'(lo_in[a]) - NW'(s_in[a]);
				nhi_s1[a] <= NW'(hi_in[a]) - NW'(s_in[a]);
			end
		end
	end

	// stage 2: magnitudes, signs, parallel test, divider seed
	logic signed [NW-1:0] thr_sn;
	logic signed [NW-1:0] n_s1 [NUM_LANES];
	logic [NW-1:0]        an_c [NUM_LANES];
	logic [NUM_AXES-1:0]  par_c;
	logic                 pm_c;

	assign thr_sn = signed'(NW'(thr_q));

	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			n_s1[l] = l[0] ? nhi_s1[l/2] : nlo_s1[l/2];
			an_c[l] = n_s1[l][NW-1] ? NW'(-n_s1[l]) : NW'(n_s1[l]);
		end
	end

	// a zero direction is parallel whatever the threshold
	always_comb begin
		pm_c = 1'b0;
		for (int a = 0; a < NUM_AXES; a++) begin
			par_c[a] = (d_s1[a] == '0) || ((d_s1[a] < thr_sn) && (d_s1[a] > -thr_sn));
			if (par_c[a] && !(nlo_s1[a][NW-1] && (nhi_s1[a] > 0))) begin
				pm_c = 1'b1;
			end
		end
	end

	logic [NW-1:0]        ad_s2  [NUM_AXES];
	logic [NW-1:0]        rem_s2 [NUM_LANES];
	logic [NW-1:0]        qs_s2  [NUM_LANES];
	logic [NUM_LANES-1:0] neg_s2;
	logic [NUM_AXES-1:0]  par_s2;
	logic                 pm_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				ad_s2[a] <= d_s1[a][NW-1] ? NW'(-d_s1[a]) : NW'(d_s1[a]);
			end
			par_s2 <= par_c;
			pm_s2  <= pm_c;
			for (int l = 0; l < NUM_LANES; l++) begin
				rem_s2[l] <= an_c[l] >> (NW - FRAC_BITS);
				qs_s2[l]  <= an_c[l] << FRAC_BITS;
				neg_s2[l] <= n_s1[l][NW-1] ^ d_s1[l/2][NW-1];
			end
		end
	end

	// divider: one quotient bit per stage, dividend bits shift out as quotient bits shift in
	logic [NW-1:0]        ad_sk  [NW][NUM_AXES];
	logic [NW-1:0]        rem_sk [NW][NUM_LANES];
	logic [NW-1:0]        qs_sk  [NW][NUM_LANES];
	logic [NUM_LANES-1:0] sat_sk [NW];
	logic [NUM_LANES-1:0] neg_sk [NW];
	logic [NUM_AXES-1:0]  par_sk [NW];
	logic                 pm_sk  [NW];

	generate
		for (gk = 0; gk < NW; gk++) begin : g_div
			logic [NW-1:0]        ad_i  [NUM_AXES];
			logic [NW-1:0]        rem_i [NUM_LANES];
			logic [NW-1:0]        qs_i  [NUM_LANES];
			logic [NUM_LANES-1:0] sat_i;
			logic [NUM_LANES-1:0] neg_i;
			logic [NUM_AXES-1:0]  par_i;
			logic                 pm_i;
			logic [NW-1:0]        rem_n [NUM_LANES];
			logic [NW-1:0]        qs_n  [NUM_LANES];
			logic [NUM_LANES-1:0] sat_n;
			logic [NW:0]          rs    [NUM_LANES];

			if (gk == 0) begin : g_src0
				assign ad_i  = ad_s2;
				assign rem_i = rem_s2;
				assign qs_i  = qs_s2;
				assign sat_i = '0;
				assign neg_i = neg_s2;
				assign par_i = par_s2;
				assign pm_i  = pm_s2;
			end else begin : g_srcn
				assign ad_i  = ad_sk[gk-1];
				assign rem_i = rem_sk[gk-1];
				assign qs_i  = qs_sk[gk-1];
				assign sat_i = sat_sk[gk-1];
				assign neg_i = neg_sk[gk-1];
				assign par_i = par_sk[gk-1];
				assign pm_i  = pm_sk[gk-1];
			end

			always_comb begin
				for (int l = 0; l < NUM_LANES; l++) begin
					rs[l] = {rem_i[l], qs_i[l][NW-1]};
					// seed overflow: quotient would not fit in NW bits
					sat_n[l] = (gk == 0) ? (rem_i[l] >= ad_i[l/2]) : sat_i[l];
					if (rs[l] >= {1'b0, ad_i[l/2]}) begin
						rem_n[l] = NW'(rs[l] - {1'b0, ad_i[l/2]});
						qs_n[l]  = {qs_i[l][NW-2:0], 1'b1};
					end else begin
						rem_n[l] = NW'(rs[l]);
						qs_n[l]  = {qs_i[l][NW-2:0], 1'b0};
					end
				end
			end

			always_ff @(posedge clk) begin
				if (en[2+gk]) begin
					ad_sk[gk]  <= ad_i;
					rem_sk[gk] <= rem_n;
					qs_sk[gk]  <= qs_n;
					sat_sk[gk] <= sat_n;
					neg_sk[gk] <= neg_i;
					par_sk[gk] <= par_i;
					pm_sk[gk]  <= pm_i;
				end
			end
		end
	endgenerate

	// stage A: saturate and apply sign
	logic signed [COORD_BITS-1:0] t_sA [NUM_LANES];
	logic [NUM_AXES-1:0]          par_sA;
	logic                         pm_sA;

	always_ff @(posedge clk) begin
		if (en[SA]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				if (neg_sk[NW-1][l]) begin
					t_sA[l] <= COORD_BITS'((sat_sk[NW-1][l] || (qs_sk[NW-1][l] > LIM))
						? (NW'(0) - LIM) : (NW'(0) - qs_sk[NW-1][l]));
				end else begin
					t_sA[l] <= COORD_BITS'((sat_sk[NW-1][l] || (qs_sk[NW-1][l] >= LIM))
						? (LIM - NW'(1)) : qs_sk[NW-1][l]);
				end
			end
			par_sA <= par_sk[NW-1];
			pm_sA  <= pm_sk[NW-1];
		end
	end

	// stage B: order entry and exit per axis
	logic signed [COORD_BITS-1:0] lo_sB [NUM_AXES];
	logic signed [COORD_BITS-1:0] hi_sB [NUM_AXES];
	logic [NUM_AXES-1:0]          p_sB;
	logic [NUM_AXES-1:0]          par_sB;
	logic                         pm_sB;

	always_ff @(posedge clk) begin
		if (en[SB]) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (t_sA[2*a] > t_sA[2*a+1]) begin
					lo_sB[a] <= t_sA[2*a+1];
					hi_sB[a] <= t_sA[2*a];
					p_sB[a]  <= 1'b1;
				end else begin
					lo_sB[a] <= t_sA[2*a];
					hi_sB[a] <= t_sA[2*a+1];
					p_sB[a]  <= 1'b0;
				end
			end
			par_sB <= par_sA;
			pm_sB  <= pm_sA;
		end
	end

	// stage C: narrow the interval over x and y
	acc_t acc_init;
	acc_t acc_x;
	acc_t acc_y;
	acc_t acc_sC;
	logic signed [COORD_BITS-1:0] lo_z_sC;
	logic signed [COORD_BITS-1:0] hi_z_sC;
	logic                         p_z_sC;
	logic                         par_z_sC;

	always_comb begin
		acc_init.tmin = '0;
		acc_init.tmax = T_ONE;
		acc_init.axis = AXIS_X;
		acc_init.pos  = 1'b0;
		acc_init.miss = pm_sB;
		acc_x = slab_step(acc_init, lo_sB[0], hi_sB[0], p_sB[0], par_sB[0], AXIS_X);
		acc_y = slab_step(acc_x, lo_sB[1], hi_sB[1], p_sB[1], par_sB[1], AXIS_Y);
	end

	always_ff @(posedge clk) begin
		if (en[SC]) begin
			acc_sC   <= acc_y;
			lo_z_sC  <= lo_sB[2];
			hi_z_sC  <= hi_sB[2];
			p_z_sC   <= p_sB[2];
			par_z_sC <= par_sB[2];
		end
	end

	// stage D: z axis and result register
	acc_t acc_z;
	logic hit_c;

	always_comb begin
		acc_z = slab_step(acc_sC, lo_z_sC, hi_z_sC, p_z_sC, par_z_sC, AXIS_Z);
		hit_c = !acc_z.miss && (acc_z.tmin > 0);
	end

	logic              hit_sD;
	logic [FRAC_BITS:0] t_sD;
	logic [1:0]        axis_sD;
	logic              pos_sD;

	always_ff @(posedge clk) begin
		if (en[SD]) begin
			hit_sD  <= hit_c;
			t_sD    <= hit_c ? acc_z.tmin[FRAC_BITS:0] : '0;
			axis_sD <= hit_c ? acc_z.axis : AXIS_X;
			pos_sD  <= hit_c && acc_z.pos;
		end
	end

	assign hit             = hit_sD;
	assign entry_t         = t_sD;
	assign normal_axis     = axis_sD;
	assign normal_positive = pos_sD;

endmodule
`default_nettype wire

// ----- src/sbsi_checker.sv -----
// Port-level checks for the segment/box slab intersection block, with bind.
`timescale 1ns / 1ps
`default_nettype none
module sbsi_checker #(
	parameter int FRAC_BITS = 16
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               hit,
	input wire logic [FRAC_BITS:0] entry_t,
	input wire logic [1:0]         normal_axis,
	input wire logic               normal_positive
);
	import sbsi_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(entry_t) && $stable(hit))
		else $error("result beat changed under stall");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> entry_t == '0 && normal_axis == AXIS_X && !normal_positive)
		else $error("miss beat carries non-zero fields");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> entry_t != '0 && (!entry_t[FRAC_BITS] || entry_t[FRAC_BITS-1:0] == '0))
		else $error("entry t outside (0,1]");

	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_axis == AXIS_X || normal_axis == AXIS_Y || normal_axis == AXIS_Z)
		else $error("normal axis out of range");

endmodule

bind segment_box_slab_intersection sbsi_checker #(.FRAC_BITS(FRAC_BITS)) u_sbsi_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.hit(hit),
	.entry_t(entry_t),
	.normal_axis(normal_axis),
	.normal_positive(normal_positive)
);
`default_nettype wire

// ----- dv/segment_box_slab_intersection_tb.sv -----
// Self-checking testbench for the segment/box slab intersection block.
`timescale 1ns / 1ps
module segment_box_slab_intersection_tb;
	import sbsi_pkg::*;

	typedef struct packed {
		logic [11:0][31:0] v;   // start xyz, end xyz, min xyz, max xyz
	} query_t;

	typedef struct packed {
		logic        hit;
		logic [16:0] entry_t;
		logic [1:0]  normal_axis;
		logic        normal_positive;
	} slab_hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [THR_BITS-1:0] parallel_threshold = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	query_t cur = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [16:0] entry_t;
	logic [1:0] normal_axis;
	logic normal_positive;

	query_t pending_queries[$];
	slab_hit_t expected_hits[$];
	logic [THR_BITS-1:0] thr_shadow = THR_RESET;
	logic failed = 1'b0;
	int unsigned cycle_no = 0;

	always #5 clk = ~clk;

	segment_box_slab_intersection i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .parallel_threshold(parallel_threshold),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(cur.v[0]), .start_y(cur.v[1]), .start_z(cur.v[2]),
		.end_x(cur.v[3]), .end_y(cur.v[4]), .end_z(cur.v[5]),
		.box_min_x(cur.v[6]), .box_min_y(cur.v[7]), .box_min_z(cur.v[8]),
		.box_max_x(cur.v[9]), .box_max_y(cur.v[10]), .box_max_z(cur.v[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .entry_t(entry_t), .normal_axis(normal_axis),
		.normal_positive(normal_positive)
	);

	function automatic longint slab_div(longint n, longint d);
		longint an, ad, q, r, lim;
		logic neg, sat;
		an = n < 0 ? -n : n;
		ad = d < 0 ? -d : d;
		neg = (n < 0) != (d < 0);
		lim = longint'(1) << 31;
		q = an / ad;
		r = an % ad;
		sat = q > lim;
		for (int i = 0; i < 16 && !sat; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= ad) begin
				r = r - ad;
				q = q | 1;
			end
			if (q > lim)
				sat = 1'b1;
		end
		if (neg) begin
			if (sat || q > lim)
				q = lim;
			return -q;
		end
		if (sat || q > lim - 1)
			q = lim - 1;
		return q;
	endfunction

	function automatic slab_hit_t slab_predict(query_t qy, logic [THR_BITS-1:0] thr);
		longint tmin, tmax, s, e, lo, hi, d, t1, t2, tt;
		logic [1:0] ax;
		logic pos, p, miss;
		slab_hit_t res;
		tmin = 0;
		tmax = longint'(1) << 16;
		ax = AXIS_X;
		pos = 1'b0;
		miss = 1'b0;
		res = '0;
		for (int i = 0; i < NUM_AXES && !miss; i++) begin
			s = longint'($signed(qy.v[i]));
			e = longint'($signed(qy.v[3 + i]));
			lo = longint'($signed(qy.v[6 + i]));
			hi = longint'($signed(qy.v[9 + i]));
			d = e - s;
			if (d == 0 || (d < 0 ? -d : d) < longint'(thr)) begin
				if (s <= lo || s >= hi)
					miss = 1'b1;
			end else begin
				t1 = slab_div(lo - s, d);
				t2 = slab_div(hi - s, d);
				p = 1'b0;
				if (t1 > t2) begin
					tt = t1;
					t1 = t2;
					t2 = tt;
					p = 1'b1;
				end
				if (t1 > tmin) begin
					tmin = t1;
					ax = 2'(i);
					pos = p;
				end
				if (t2 < tmax)
					tmax = t2;
				if (tmin > tmax)
					miss = 1'b1;
			end
		end
		if (!miss && tmin > 0) begin
			res.hit = 1'b1;
			res.entry_t = tmin[16:0];
			res.normal_axis = ax;
			res.normal_positive = pos;
		end
		return res;
	endfunction

	// quiet window: no idling on either side
	function automatic logic take_gap();
		if (cycle_no > 3000 && cycle_no < 5000)
			return 1'b0;
		return $urandom_range(99, 0) < 15;
	endfunction

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (in_valid && !in_stall)
			expected_hits.push_back(slab_predict(cur, thr_shadow));
		if (!in_valid || !in_stall) begin
			if (pending_queries.size() != 0 && !take_gap()) begin
				cur <= pending_queries.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		slab_hit_t exp_hit;
		out_stall <= take_gap();
		if (out_valid && !out_stall) begin
			if (expected_hits.size() == 0) begin
				$error("result beat with nothing expected");
				failed <= 1'b1;
			end else begin
				exp_hit = expected_hits.pop_front();
				if (hit !== exp_hit.hit) begin
					$error("hit: expected %0d actual %0d", exp_hit.hit, hit);
					failed <= 1'b1;
				end
				if (entry_t !== exp_hit.entry_t) begin
					$error("entry_t: expected %0d actual %0d", exp_hit.entry_t, entry_t);
					failed <= 1'b1;
				end
				if (normal_axis !== exp_hit.normal_axis) begin
					$error("normal_axis: expected %0d actual %0d",
						exp_hit.normal_axis, normal_axis);
					failed <= 1'b1;
				end
				if (normal_positive !== exp_hit.normal_positive) begin
					$error("normal_positive: expected %0d actual %0d",
						exp_hit.normal_positive, normal_positive);
					failed <= 1'b1;
				end
			end
		end
	end

	function automatic logic [31:0] rnd_scaled();
		logic [31:0] r;
		r = $urandom();
		return $signed(r) >>> $urandom_range(31, 0);
	endfunction

	// box around a centre (min and max sometimes swapped) with the segment passing near it; some axes near-parallel
	function automatic query_t shaped_query(logic [THR_BITS-1:0] thr);
		query_t qy;
		longint c, h, s;
		for (int a = 0; a < NUM_AXES; a++) begin
			c = longint'($signed(rnd_scaled())) >>> 6;
			h = $urandom_range(1 << $urandom_range(22, 2), 1);
			qy.v[6 + a] = 32'(c - h);
			qy.v[9 + a] = 32'(c + h);
			if ($urandom_range(15, 0) == 0) begin
				qy.v[6 + a] = 32'(c + h);
				qy.v[9 + a] = 32'(c - h);
			end
			s = c + longint'($urandom_range(4 * h, 0)) - 2 * h;
			if ($urandom_range(1, 0))
				s = c + (($urandom_range(1, 0)) ? h : -h) * $urandom_range(4, 1);
			qy.v[a] = 32'(s);
			if ($urandom_range(5, 0) == 0)
				qy.v[3 + a] = 32'(s + longint'($urandom_range(thr + 2, 0))
					* ($urandom_range(1, 0) ? 1 : -1));
			else
				qy.v[3 + a] = 32'(2 * c - s + longint'($urandom_range(2 * h, 0)) - h);
		end
		return qy;
	endfunction

	task automatic write_threshold(logic [THR_BITS-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		parallel_threshold <= val;
		do @(posedge clk); while (!cfg_ready);
		thr_shadow = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_queries.size() != 0 || in_valid || expected_hits.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic query_t mk(longint s, longint e, longint lo, longint hi);
		query_t qy;
		for (int a = 0; a < NUM_AXES; a++) begin
			qy.v[a] = 32'(s);
			qy.v[3 + a] = 32'(e);
			qy.v[6 + a] = 32'(lo);
			qy.v[9 + a] = 32'(hi);
		end
		return qy;
	endfunction

	initial begin
		logic [THR_BITS-1:0] thr_list[6];
		query_t qy;
		thr_list = '{THR_RESET, '0, 17'd65536, 17'h1FFFF, 17'(0), 17'd4096};
		thr_list[4] = 17'($urandom());
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			write_threshold(thr_list[ph]);
			if (ph == 0) begin
				pending_queries.push_back('0);
				pending_queries.push_back('1);
				pending_queries.push_back(mk(32'sh80000000, 32'sh7FFFFFFF,
					-65536, 65536));
				pending_queries.push_back(mk(32'sh7FFFFFFF, 32'sh80000000,
					-65536, 65536));
				pending_queries.push_back(mk(-2147483648, 2147483647,
					-2147483648, 2147483647));
				pending_queries.push_back(mk(0, 1, -5, 5));       // start inside
				pending_queries.push_back(mk(-10, 1, 30, 40));    // box beyond the segment end
				pending_queries.push_back(mk(10, -1, -40, -30));
				pending_queries.push_back(mk(5, 5, 0, 10));       // zero direction
				pending_queries.push_back(mk(5, 5, 5, 10));       // on the slab edge
				pending_queries.push_back(mk(-200000, 200000, 100, -100)); // inverted box
				for (int a = 0; a < NUM_AXES; a++)
					for (int sg = 0; sg < 2; sg++) begin
						qy = mk(0, 0, -65536, 65536);
						qy.v[a] = 32'(sg ? 196608 : -196608);
						qy.v[3 + a] = 32'(sg ? -196608 : 196608);
						pending_queries.push_back(qy);  // axis entry, each face
					end
				qy = mk(-131072, 131072, -65536, 65536);
				qy.v[4] = 32'(1);                       // y travels about half as far
				pending_queries.push_back(qy);
				qy = mk(-131072, 131072, -65536, 65536);
				qy.v[2] = 32'(65536);
				qy.v[5] = 32'(65536);                   // parallel, on the max face
				pending_queries.push_back(qy);
				pending_queries.push_back(mk(0, 65536, 65536, 131072)); // t of exactly 1
			end
			for (int n = 0; n < 270; n++) begin
				if ($urandom_range(9, 0) < 8) begin
					pending_queries.push_back(shaped_query(thr_shadow));
				end else begin
					for (int k = 0; k < 12; k++)
						qy.v[k] = $urandom_range(1, 0) ? $urandom() : rnd_scaled();
					pending_queries.push_back(qy);
				end
			end
			drain();
		end
		if (!failed)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#5ms;
		$display("status: fail");
		$finish;
	end

endmodule
